[src/itp_pkg.sv]
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNMATCHED = 2'd2
  } err_t;

  // one result word handed from the sequencer to the output register
  typedef struct packed {
    logic [7:0] symbol;
    logic       has_symbol;
    logic       run_last;
    logic       expression_done;
    err_t       error_code;
  } res_t;

  // stack memory request
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CH_PLUS, CH_MINUS: p = 2'd1;
      CH_STAR, CH_SLASH: p = 2'd2;
      CH_CARET:          p = 2'd3;
      default:           p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
  endfunction

endpackage

[src/itp_stack.sv]
module itp_stack (
  input  logic                  clk,
  input  itp_pkg::stk_req_t     req,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [itp_pkg::STACK_DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data <= mem[req.raddr];
  end

endmodule

[src/itp_pop_unit.sv]
module itp_pop_unit (
  input  logic [7:0] top_char,
  input  logic [7:0] in_char,
  input  logic       right_assoc,
  output logic       pop
);

  logic [1:0] top_prec;
  logic [1:0] in_prec;
  logic       hold_equal;

  assign top_prec   = itp_pkg::prec_of(top_char);
  assign in_prec    = itp_pkg::prec_of(in_char);
  // a right-associative caret leaves an equal-precedence top in place
  assign hold_equal = (in_char == itp_pkg::CH_CARET) && right_assoc;
  assign pop        = (top_prec > in_prec) || ((top_prec == in_prec) && !hold_equal);

endmodule

[src/itp_ctrl.sv]
module itp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_char,
  input  logic                 in_last,
  output logic [7:0]           cur_char,
  input  logic                 pop_hit,
  input  logic                 out_free,
  output logic                 res_valid,
  output itp_pkg::res_t        res,
  output itp_pkg::stk_req_t    stk,
  input  logic [7:0]           rd_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PUSH,
    S_FIN,
    S_DRAIN,
    S_FLUSH
  } state_t;

  state_t                       state, state_next;
  logic [7:0]                   ch, ch_next;
  logic                         last, last_next;
  logic [itp_pkg::CNT_W-1:0]    count, count_next;
  itp_pkg::err_t                err, err_next;
  logic                         any, any_next;
  logic                         pend_valid, pend_valid_next;
  logic [7:0]                   pend_sym, pend_sym_next;
  logic                         pend_has, pend_has_next;

  logic                         go;
  logic                         prod;
  logic [7:0]                   prod_sym;
  logic                         prod_has;
  logic [itp_pkg::ADDR_W-1:0]   top_addr;
  logic [itp_pkg::ADDR_W-1:0]   below_addr;
  logic                         one_left;

  assign in_ready   = (state == S_IDLE);
  assign cur_char   = ch;
  assign top_addr   = itp_pkg::ADDR_W'(count - itp_pkg::CNT_W'(1));
  assign below_addr = itp_pkg::ADDR_W'(count - itp_pkg::CNT_W'(2));
  assign one_left   = (count == itp_pkg::CNT_W'(1));
  // a new result may replace the pending one only if the output can take it
  assign go         = !pend_valid || out_free;

  always_comb begin
    state_next      = state;
    ch_next         = ch;
    last_next       = last;
    count_next      = count;
    err_next        = err;
    any_next        = any;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    pend_has_next   = pend_has;
    prod            = 1'b0;
    prod_sym        = rd_data;
    prod_has        = 1'b1;
    res_valid       = 1'b0;
    res             = '{symbol: pend_sym, has_symbol: pend_has, run_last: 1'b0,
                        expression_done: 1'b0, error_code: itp_pkg::ERR_NONE};
    stk             = '{we: 1'b0, waddr: count[itp_pkg::ADDR_W-1:0], wdata: ch,
                        raddr: top_addr};

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ch_next    = in_char;
          last_next  = in_last;
          any_next   = 1'b0;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (err != itp_pkg::ERR_NONE) begin
          state_next = S_FIN;
        end else if (itp_pkg::is_letter(ch)) begin
          if (go) begin
            prod       = 1'b1;
            prod_sym   = ch;
            state_next = S_FIN;
          end
        end else if (ch == itp_pkg::CH_LPAREN) begin
          state_next = S_PUSH;
        end else if (count != '0) begin
          state_next = S_SCAN;
        end else if (ch == itp_pkg::CH_RPAREN) begin
          err_next   = itp_pkg::ERR_UNMATCHED;
          state_next = S_FIN;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_SCAN: begin
        if (ch == itp_pkg::CH_RPAREN) begin
          if (rd_data == itp_pkg::CH_LPAREN) begin
            count_next = count - itp_pkg::CNT_W'(1);
            state_next = S_FIN;
          end else if (go) begin
            prod       = 1'b1;
            count_next = count - itp_pkg::CNT_W'(1);
            stk.raddr  = below_addr;
            if (one_left) begin
              err_next   = itp_pkg::ERR_UNMATCHED;
              state_next = S_FIN;
            end
          end
        end else if (pop_hit) begin
          if (go) begin
            prod       = 1'b1;
            count_next = count - itp_pkg::CNT_W'(1);
            stk.raddr  = below_addr;
            if (one_left) begin
              state_next = S_PUSH;
            end
          end
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH)) begin
          err_next = itp_pkg::ERR_OVERFLOW;
        end else begin
          stk.we     = 1'b1;
          count_next = count + itp_pkg::CNT_W'(1);
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (last && (err == itp_pkg::ERR_NONE) && (count != '0)) begin
          state_next = S_DRAIN;
        end else if (last && ((err != itp_pkg::ERR_NONE) || !any)) begin
          // bare end marker
          if (go) begin
            prod       = 1'b1;
            prod_sym   = 8'h00;
            prod_has   = 1'b0;
            state_next = S_FLUSH;
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_DRAIN: begin
        if (go) begin
          prod       = 1'b1;
          count_next = count - itp_pkg::CNT_W'(1);
          stk.raddr  = below_addr;
          if (one_left) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          if (pend_valid) begin
            res_valid           = 1'b1;
            res.run_last        = 1'b1;
            res.expression_done = last;
            res.error_code      = last ? err : itp_pkg::ERR_NONE;
          end
          pend_valid_next = 1'b0;
          if (last) begin
            count_next = '0;
            err_next   = itp_pkg::ERR_NONE;
          end
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // hand the older result on, keep the new one until we know what follows
    if (prod) begin
      res_valid       = pend_valid;
      pend_valid_next = 1'b1;
      pend_sym_next   = prod_sym;
      pend_has_next   = prod_has;
      any_next        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      err        <= itp_pkg::ERR_NONE;
      any        <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      err        <= err_next;
      any        <= any_next;
      pend_valid <= pend_valid_next;
    end
    ch       <= ch_next;
    last     <= last_next;
    pend_sym <= pend_sym_next;
    pend_has <= pend_has_next;
  end

endmodule

[src/infix_to_postfix_converter.sv]
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tdata[7:0] character, tlast expr_end
// m_*       out  m_tvalid/m_tready  tdata[7:0] symbol, [8] expression_done,
//                                   [10:9] error_code; tuser has_symbol;
//                                   tlast run_last
// cfg_*     in   cfg_write_en       cfg_write_data power_right_assoc
//
// A word passes accept, decode, finish and flush, plus a push step per push,
// a step per entry popped or drained, and a step for a compare that keeps the top
// (a matching open paren, or an entry the operator leaves in place).
// rst (synchronous) empties the stack and clears a latched error; the stack
// memory needs no clearing. A stalled m_tready holds the sequencer at its next
// result, and s_tready is high only while the block is idle between words.
module infix_to_postfix_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,        // [7:0] character
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,        // [7:0] symbol, [8] expression_done, [10:9] error_code
  output logic        m_tuser,        // [0] has_symbol
  output logic        m_tlast,
  input  logic        cfg_write_en,
  input  logic        cfg_write_data
);

  logic                power_right_assoc;
  logic                out_free;
  logic                res_valid;
  itp_pkg::res_t       res;
  itp_pkg::res_t       out_word;
  itp_pkg::stk_req_t   stk;
  logic [7:0]          rd_data;
  logic [7:0]          cur_char;
  logic                pop_hit;

  // caret associativity; the user writes it only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      power_right_assoc <= 1'b1;
    end else if (cfg_write_en) begin
      power_right_assoc <= cfg_write_data;
    end
  end

  itp_stack u_stack (
    .clk     (clk),
    .req     (stk),
    .rd_data (rd_data)
  );

  // precedence compare of the incoming operator against the stack top
  itp_pop_unit u_pop (
    .top_char    (rd_data),
    .in_char     (cur_char),
    .right_assoc (power_right_assoc),
    .pop         (pop_hit)
  );

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .cur_char  (cur_char),
    .pop_hit   (pop_hit),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .stk       (stk),
    .rd_data   (rd_data)
  );

  // output register: load when empty or when the current word is taken
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
    if (out_free && res_valid) begin
      out_word <= res;
    end
  end

  assign m_tdata = {5'b0, out_word.error_code, out_word.expression_done, out_word.symbol};
  assign m_tuser = out_word.has_symbol;
  assign m_tlast = out_word.run_last;

endmodule

[src/itp_checker.sv]
module itp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast)))
    else $error("result word changed while stalled");

  // end of expression closes the run of its word
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> m_tlast)
    else $error("expression_done without run_last");

  // error code only on the closing word, never an unused code
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[10:9] != 2'd0)) |-> (m_tdata[8] && (m_tdata[10:9] != 2'd3)))
    else $error("bad error code placement");

  // a bare marker carries no symbol and closes an expression
  a_bare: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> ((m_tdata[7:0] == 8'h00) && m_tdata[8]))
    else $error("malformed end marker");

  // input is never accepted back to back
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted on consecutive cycles");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

[verif/tb_infix_to_postfix_converter.sv]
module tb_infix_to_postfix_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 60;    // covers a word that is still popping with nothing due

  // Shunting-yard predictor plus the queue of postfix words still owed by the block.
  class postfix_scoreboard;
    logic [7:0]     op_stack [itp_pkg::STACK_DEPTH];
    int             depth_used;
    itp_pkg::err_t  err_held;
    bit             caret_right;
    itp_pkg::res_t  pending_symbols[$];
    int             fail_count;

    function new();
      depth_used  = 0;
      err_held    = itp_pkg::ERR_NONE;
      caret_right = 1'b1;
      fail_count  = 0;
    endfunction

    function int op_rank(logic [7:0] c);
      int r;
      case (c)
        itp_pkg::CH_PLUS, itp_pkg::CH_MINUS: r = 1;
        itp_pkg::CH_STAR, itp_pkg::CH_SLASH: r = 2;
        itp_pkg::CH_CARET:                   r = 3;
        default:                             r = 0;
      endcase
      return r;
    endfunction

    function itp_pkg::res_t sym_word(logic [7:0] c, bit has);
      itp_pkg::res_t w;
      w = '0;
      w.symbol     = c;
      w.has_symbol = has;
      return w;
    endfunction

    function void push_op(logic [7:0] c);
      if (depth_used >= itp_pkg::STACK_DEPTH) begin
        err_held = itp_pkg::ERR_OVERFLOW;
      end else begin
        op_stack[depth_used] = c;
        depth_used++;
      end
    endfunction

    // Note one accepted character; queue the words it produces. Returns 0 when
    // the character is swallowed because an error is already latched.
    function bit note_char(logic [7:0] ch, bit last);
      itp_pkg::res_t made[$];
      itp_pkg::res_t tail;
      logic [7:0]    top;
      bit            found;
      bit            live;
      int            rank;
      live = (err_held == itp_pkg::ERR_NONE);
      if (live) begin
        if ((ch >= itp_pkg::CH_LC_A && ch <= itp_pkg::CH_LC_Z) ||
            (ch >= itp_pkg::CH_UC_A && ch <= itp_pkg::CH_UC_Z)) begin
          made.push_back(sym_word(ch, 1'b1));
        end else if (ch == itp_pkg::CH_LPAREN) begin
          push_op(ch);
        end else if (ch == itp_pkg::CH_RPAREN) begin
          found = 1'b0;
          while (depth_used > 0) begin
            depth_used--;
            top = op_stack[depth_used];
            if (top == itp_pkg::CH_LPAREN) begin
              found = 1'b1;
              break;
            end
            made.push_back(sym_word(top, 1'b1));
          end
          if (!found) err_held = itp_pkg::ERR_UNMATCHED;
        end else begin
          rank = op_rank(ch);
          while (depth_used > 0) begin
            top = op_stack[depth_used-1];
            if (op_rank(top) < rank) break;
            // equal rank pops, except caret onto caret in right-assoc mode
            if (op_rank(top) == rank && ch == itp_pkg::CH_CARET && caret_right) break;
            made.push_back(sym_word(top, 1'b1));
            depth_used--;
          end
          push_op(ch);
        end
      end
      if (last) begin
        if (err_held == itp_pkg::ERR_NONE) begin
          while (depth_used > 0) begin
            depth_used--;
            made.push_back(sym_word(op_stack[depth_used], 1'b1));
          end
        end
        if (err_held != itp_pkg::ERR_NONE || made.size() == 0) begin
          made.push_back(sym_word(8'h00, 1'b0));
        end
        tail = made[made.size()-1];
        tail.expression_done = 1'b1;
        tail.error_code      = err_held;
        made[made.size()-1]  = tail;
        depth_used = 0;
        err_held   = itp_pkg::ERR_NONE;
      end
      if (made.size() > 0) begin
        tail = made[made.size()-1];
        tail.run_last = 1'b1;
        made[made.size()-1] = tail;
      end
      foreach (made[i]) pending_symbols.push_back(made[i]);
      return live;
    endfunction

    function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
      if (got_v !== want_v) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want_v, got_v);
        fail_count++;
      end
    endfunction

    function void check_word(itp_pkg::res_t got);
      itp_pkg::res_t want;
      if (pending_symbols.size() == 0) begin
        $error("unexpected word: symbol %0h has_symbol %0b", got.symbol, got.has_symbol);
        fail_count++;
        return;
      end
      want = pending_symbols.pop_front();
      compare_field("symbol", want.symbol, got.symbol);
      compare_field("has_symbol", want.has_symbol, got.has_symbol);
      compare_field("run_last", want.run_last, got.run_last);
      compare_field("expression_done", want.expression_done, got.expression_done);
      compare_field("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        s_tvalid       = 1'b0;
  logic [7:0]  s_tdata        = 8'h00;   // [7:0] character
  logic        s_tlast        = 1'b0;    // expr_end
  logic        m_tready       = 1'b0;
  logic        cfg_write_en   = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;                  // [7:0] symbol, [8] expression_done, [10:9] error_code
  logic        m_tuser;                  // [0] has_symbol
  logic        m_tlast;                  // run_last

  postfix_scoreboard sb = new();

  bit         src_idle_en = 1'b1;
  bit         snk_idle_en = 1'b1;
  bit         hold_req    = 1'b0;
  bit         hold_done   = 1'b0;
  int         cycle_count = 0;
  logic [7:0] expr_text[$];              // characters of the expression being built

  infix_to_postfix_converter DUT (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs or loses words.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up with a pending result and stops taking input words.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= !(snk_idle_en && $urandom_range(99) < 15);
      end
    end
  end

  // Output monitor: unpack each accepted word and check it against the oldest
  // expected postfix word.
  always @(posedge clk) begin
    itp_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.symbol          = m_tdata[7:0];
      got.expression_done = m_tdata[8];
      got.error_code      = itp_pkg::err_t'(m_tdata[10:9]);
      got.has_symbol      = m_tuser;
      got.run_last        = m_tlast;
      sb.check_word(got);
    end
  end

  // Offer one character and hold it until the block takes it. Valid stays high
  // on return so back-to-back words need no extra step.
  task automatic send_word(input logic [7:0] ch, input bit last, output bit live);
    if (src_idle_en && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    live = sb.note_char(ch, last);
  endtask

  task automatic send_expr(output int live_items);
    bit live;
    live_items = 0;
    foreach (expr_text[i]) begin
      send_word(expr_text[i], i == expr_text.size() - 1, live);
      live_items += live;
    end
  endtask

  task automatic send_text(input string s);
    int unused;
    expr_text.delete();
    for (int i = 0; i < s.len(); i++) expr_text.push_back(s[i]);
    send_expr(unused);
  endtask

  // Drop valid and hold until every owed word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_symbols.size() > 0) @(posedge clk);
  endtask

  // Only write the mode bit with the block idle.
  task automatic write_caret_mode(input bit right);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= right;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    sb.caret_right = right;
  endtask

  function automatic logic [7:0] pick_letter();
    return ($urandom_range(1) ? itp_pkg::CH_LC_A : itp_pkg::CH_UC_A) +
           8'($urandom_range(0, 25));
  endfunction

  function automatic void add_operand(input int lvl);
    if (lvl < 3 && $urandom_range(99) < 25) begin
      expr_text.push_back(itp_pkg::CH_LPAREN);
      add_expr(lvl + 1);
      expr_text.push_back(itp_pkg::CH_RPAREN);
    end else begin
      expr_text.push_back(pick_letter());
    end
  endfunction

  // Well-formed infix text; caret is weighted up to exercise associativity.
  function automatic void add_expr(input int lvl);
    int terms;
    int r;
    add_operand(lvl);
    terms = $urandom_range(0, 3);
    repeat (terms) begin
      r = $urandom_range(99);
      if (r < 15)      expr_text.push_back(itp_pkg::CH_PLUS);
      else if (r < 30) expr_text.push_back(itp_pkg::CH_MINUS);
      else if (r < 45) expr_text.push_back(itp_pkg::CH_STAR);
      else if (r < 60) expr_text.push_back(itp_pkg::CH_SLASH);
      else if (r < 92) expr_text.push_back(itp_pkg::CH_CARET);
      else             expr_text.push_back(8'($urandom_range(128, 255)));  // rank-0 operator
      add_operand(lvl);
    end
  endfunction

  // Mostly well-formed expressions, some nested to the stack limit and past it,
  // some with a paren inserted or a character dropped, and some raw noise.
  task automatic run_random_phase(input int target);
    int got_items;
    int live_items;
    int kind;
    int n;
    int pos;
    got_items = 0;
    while (got_items < target) begin
      expr_text.delete();
      kind = $urandom_range(99);
      if (kind < 65) begin
        add_expr(0);
      end else if (kind < 73) begin
        n = $urandom_range(28, 36);
        repeat (n) expr_text.push_back(itp_pkg::CH_LPAREN);
        add_expr(2);
        repeat ($urandom_range(0, n)) expr_text.push_back(itp_pkg::CH_RPAREN);
      end else if (kind < 87) begin
        add_expr(0);
        pos = $urandom_range(0, expr_text.size() - 1);
        case ($urandom_range(2))
          0:       expr_text.insert(pos, itp_pkg::CH_RPAREN);
          1:       expr_text.insert(pos, itp_pkg::CH_LPAREN);
          default: expr_text.delete(pos);
        endcase
        if (expr_text.size() == 0) expr_text.push_back(pick_letter());
      end else begin
        repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(0, 255)));
      end
      send_expr(live_items);
      got_items += live_items;
    end
  endtask

  initial begin
    int unused;
    int guard;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: precedence, right-assoc caret, empty parens giving a bare end
    // marker, unmatched close followed by an ignored character, rank-0 operators
    // at the byte extremes, and an open paren left on the stack at the drain.
    write_caret_mode(1'b1);
    send_text("a+b*c");
    send_text("A^B^Z");
    send_text("()");
    send_text(")x");
    expr_text = {8'h00, 8'h71, 8'hFF, itp_pkg::CH_SLASH, itp_pkg::CH_MINUS};
    send_expr(unused);
    send_text("(z-");

    // Left-assoc caret; the receiver holds off long right at the start.
    write_caret_mode(1'b0);
    hold_req = 1'b1;
    run_random_phase(100);

    // Right-assoc caret at full rate on both sides.
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    write_caret_mode(1'b1);
    run_random_phase(100);

    // Left-assoc again, with one pause in the middle until all words are back.
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    write_caret_mode(1'b0);
    run_random_phase(50);
    wait_drained();
    run_random_phase(50);

    s_tvalid <= 1'b0;
    guard = 0;
    while (sb.pending_symbols.size() > 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_symbols.size() > 0) begin
      $error("%0d expected words never arrived", sb.pending_symbols.size());
      sb.fail_count++;
    end

    if (sb.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
